// ===== rtl/core/isotp_pkg.sv =====
// Shared types and constants for the ISO-TP receive reassembler.
// Used by the front end, the command queue, the back end and the top level.
package isotp_pkg;

  localparam int MAX_MESSAGE_BYTES = 4096;
  localparam int LEN_W             = 12;
  localparam int CMD_BYTES         = 8;   // data slots per command, last one unused
  localparam int CMD_IDX_W         = 3;
  localparam int CMD_DEPTH         = 2;
  localparam int CMD_PTR_W         = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W         = $clog2(CMD_DEPTH + 1);

  localparam logic [3:0] FT_FIRST       = 4'h1;
  localparam logic [3:0] FT_CONSECUTIVE = 4'h2;
  localparam logic [3:0] DLC_MAX        = 4'd8;

  localparam logic [LEN_W:0] MAX_LEN = (LEN_W + 1)'(MAX_MESSAGE_BYTES);

  localparam logic OUT_KIND_BYTE = 1'b0;
  localparam logic OUT_KIND_FC   = 1'b1;

  typedef struct packed {
    logic                        is_first;
    logic [LEN_W-1:0]            len;      // saturated announced length
    logic [CMD_IDX_W-1:0]        nbytes;   // candidate payload bytes
    logic [CMD_BYTES-1:0][7:0]   data;
  } cmd_t;

endpackage

// ===== rtl/core/isotp_front.sv =====
// Front end: classifies each received frame and builds a command for the back end.
// Depends on isotp_pkg.
module isotp_front (
  input  logic [3:0]          in_length_code,
  input  logic [7:0]          in_byte0,
  input  logic [7:0]          in_byte1,
  input  logic [7:0]          in_byte2,
  input  logic [7:0]          in_byte3,
  input  logic [7:0]          in_byte4,
  input  logic [7:0]          in_byte5,
  input  logic [7:0]          in_byte6,
  input  logic [7:0]          in_byte7,
  output logic                cmd_keep,
  output isotp_pkg::cmd_t     cmd
);
  import isotp_pkg::*;

  logic [3:0]       dlc;
  logic [3:0]       ftype;
  logic [LEN_W-1:0] len_raw;
  logic [LEN_W:0]   len_ext;
  logic [3:0]       n_ff;
  logic [3:0]       n_cf;

  always_comb begin
    dlc     = (in_length_code > DLC_MAX) ? DLC_MAX : in_length_code;
    ftype   = in_byte0[7:4];
    len_raw = {in_byte0[3:0], in_byte1};
    len_ext = {1'b0, len_raw};
    n_ff    = (dlc > 4'd2) ? dlc - 4'd2 : 4'd0;
    n_cf    = (dlc > 4'd1) ? dlc - 4'd1 : 4'd0;

    cmd_keep     = (ftype == FT_FIRST) || (ftype == FT_CONSECUTIVE);
    cmd.is_first = (ftype == FT_FIRST);
    cmd.len      = (len_ext > MAX_LEN) ? MAX_LEN[LEN_W-1:0] : len_raw;
    if (ftype == FT_FIRST) begin
      cmd.nbytes = n_ff[CMD_IDX_W-1:0];
      cmd.data   = {8'h00, 8'h00, in_byte7, in_byte6, in_byte5, in_byte4, in_byte3,
                    in_byte2};
    end else begin
      cmd.nbytes = n_cf[CMD_IDX_W-1:0];
      cmd.data   = {8'h00, in_byte7, in_byte6, in_byte5, in_byte4, in_byte3, in_byte2,
                    in_byte1};
    end
  end

endmodule

// ===== rtl/core/isotp_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on isotp_pkg.
module isotp_cmd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  isotp_pkg::cmd_t  wr_data,
  output logic             full,
  input  logic             rd_en,
  output isotp_pkg::cmd_t  rd_data,
  output logic             not_empty
);
  import isotp_pkg::*;

  cmd_t                 mem [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_wr, do_rd;

  always_comb begin
    full      = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
    not_empty = (cnt_r != '0);
    do_wr     = wr_en && !full;
    do_rd     = rd_en && not_empty;
    rd_data   = mem[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/isotp_back.sv =====
// Back end: holds the message state and streams payload bytes and flow-control
// requests into the result register. Depends on isotp_pkg.
module isotp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  isotp_pkg::cmd_t   cmd_in,
  output logic              cmd_take,
  output logic              out_kind,
  output logic [7:0]        out_payload_byte,
  output logic [11:0]       out_byte_index,
  output logic              out_message_done,
  output logic              out_last,
  output logic              out_empty,
  input  logic              out_pop
);
  import isotp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_BYTES = 3'b010,
    S_FC    = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [CMD_IDX_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0]     count_r, count_nxt;
  logic [LEN_W-1:0]     exp_r, exp_nxt;
  logic                 inprog_r, inprog_nxt;

  logic                 valid_r, valid_nxt;
  logic                 kind_r, kind_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic [LEN_W-1:0]     index_r, index_nxt;
  logic                 done_r, done_nxt;
  logic                 last_r, last_nxt;

  logic                 slot_free;
  logic                 take;
  logic                 done_now;

  always_comb begin
    slot_free = !valid_r || out_pop;
    take      = (idx_r < cmd_r.nbytes) && inprog_r;
    done_now  = (count_r + 1'b1 == exp_r);

    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    exp_nxt    = exp_r;
    inprog_nxt = inprog_r;
    cmd_take   = 1'b0;

    valid_nxt = valid_r && !out_pop;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    index_nxt = index_r;
    done_nxt  = done_r;
    last_nxt  = last_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          cmd_nxt  = cmd_in;
          idx_nxt  = '0;
          if (cmd_in.is_first) begin
            // a first frame abandons any message in progress
            exp_nxt    = cmd_in.len;
            count_nxt  = '0;
            inprog_nxt = (cmd_in.len != '0);
            state_nxt  = S_BYTES;
          end else if (inprog_r) begin
            state_nxt = S_BYTES;
          end
        end
      end
      S_BYTES: begin
        if (!take) begin
          state_nxt = cmd_r.is_first ? S_FC : S_IDLE;
        end else if (slot_free) begin
          valid_nxt  = 1'b1;
          kind_nxt   = OUT_KIND_BYTE;
          byte_nxt   = cmd_r.data[idx_r];
          index_nxt  = count_r;
          done_nxt   = done_now;
          last_nxt   = !cmd_r.is_first && ((idx_r + 1'b1 == cmd_r.nbytes) || done_now);
          count_nxt  = count_r + 1'b1;
          idx_nxt    = idx_r + 1'b1;
          if (done_now) begin
            inprog_nxt = 1'b0;
          end
        end
      end
      S_FC: begin
        if (slot_free) begin
          valid_nxt = 1'b1;
          kind_nxt  = OUT_KIND_FC;
          byte_nxt  = '0;
          index_nxt = '0;
          done_nxt  = 1'b0;
          last_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_kind         = kind_r;
    out_payload_byte = byte_r;
    out_byte_index   = index_r;
    out_message_done = done_r;
    out_last         = last_r;
    out_empty        = !valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      exp_r    <= '0;
      inprog_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      exp_r    <= exp_nxt;
      inprog_r <= inprog_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    index_r <= index_nxt;
    done_r  <= done_nxt;
    last_r  <= last_nxt;
  end

endmodule

// ===== rtl/core/iso_tp_receive_reassembler.sv =====
// ISO-TP receive reassembler, top level.
// Input: one CAN frame per item (length code and eight data bytes), push/full.
// Results: a queue of payload bytes and flow-control requests, empty/pop.
// A first frame (type 1) starts a message, streams up to six payload bytes
// and then one flow-control request. A consecutive frame (type 2) streams
// up to its length code minus one, at most seven, bytes while a message is
// in progress. Every byte carries its index; the byte that completes the
// announced length has message_done set, and the final result of each frame
// has last set. Other frame types are accepted and dropped.
// The front end classifies each item in the accept cycle and queues a
// command (two entries). The back end picks up a command, then emits its
// bytes one by one into the result register, waiting while that register is
// full, and then closes the frame; a first frame closes with its
// flow-control request. A consecutive frame picked up with no message in
// progress is dropped at pick-up.
// Reset clears the queue, the result register and the message state (idle).
// When the receiver stops popping, the result register holds, the back end
// waits, the queue fills and full rises; nothing is lost.
// Depends on isotp_pkg, isotp_front, isotp_cmd_fifo and isotp_back.
module iso_tp_receive_reassembler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [3:0]  in_length_code,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  input  logic [7:0]  in_byte3,
  input  logic [7:0]  in_byte4,
  input  logic [7:0]  in_byte5,
  input  logic [7:0]  in_byte6,
  input  logic [7:0]  in_byte7,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [11:0] out_byte_index,
  output logic        out_message_done,
  output logic        out_last
);
  import isotp_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic front_keep;
  logic fifo_full;
  logic fifo_not_empty;
  logic back_take;

  isotp_front u_front (
    .in_length_code (in_length_code),
    .in_byte0       (in_byte0),
    .in_byte1       (in_byte1),
    .in_byte2       (in_byte2),
    .in_byte3       (in_byte3),
    .in_byte4       (in_byte4),
    .in_byte5       (in_byte5),
    .in_byte6       (in_byte6),
    .in_byte7       (in_byte7),
    .cmd_keep       (front_keep),
    .cmd            (front_cmd)
  );

  isotp_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_push && front_keep),
    .wr_data   (front_cmd),
    .full      (fifo_full),
    .rd_en     (back_take),
    .rd_data   (back_cmd),
    .not_empty (fifo_not_empty)
  );

  isotp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (fifo_not_empty),
    .cmd_in           (back_cmd),
    .cmd_take         (back_take),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_message_done (out_message_done),
    .out_last         (out_last),
    .out_empty        (out_empty),
    .out_pop          (out_pop)
  );

  assign in_full = fifo_full;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for the ISO-TP receive reassembler: a directed frame table, then
// random sequences with noise, scored against a local reassembly predictor or fixed expectations.
// Depends on isotp_pkg and the iso_tp_receive_reassembler top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import isotp_pkg::*;

  typedef enum logic [1:0] {
    CHK_MODEL,    // expectation comes from the predictor
    CHK_NONE,     // frame must cause no result
    CHK_FC_ONLY   // frame must cause one flow-control request and nothing else
  } chk_t;

  typedef struct packed {
    chk_t             chk;
    logic [3:0]       dlc;
    logic [0:7][7:0]  b;
  } frame_row_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [11:0] idx;
    logic        done;
    logic        last;
  } rx_result_t;

  localparam rx_result_t FC_ALONE = '{OUT_KIND_FC, 8'h00, 12'h000, 1'b0, 1'b1};

  localparam int N_DIR = 22;
  localparam frame_row_t DIR_TBL [N_DIR] = '{
    '{CHK_NONE,    4'd8,  64'h21_11_22_33_44_55_66_77},  // consecutive while idle
    '{CHK_NONE,    4'd8,  64'h07_01_02_03_04_05_06_07},  // single frame, ignored
    '{CHK_NONE,    4'd3,  64'h30_00_00_00_00_00_00_00},  // flow control, ignored
    '{CHK_NONE,    4'd8,  64'hFF_FF_FF_FF_FF_FF_FF_FF},  // type F, ignored
    '{CHK_FC_ONLY, 4'd8,  64'h10_00_AA_BB_CC_DD_EE_FF},  // zero length
    '{CHK_NONE,    4'd8,  64'h21_01_02_03_04_05_06_07},  // still idle after zero length
    '{CHK_MODEL,   4'd8,  64'h10_14_00_FF_01_FE_80_7F},  // 20-byte message
    '{CHK_NONE,    4'd0,  64'h21_AA_AA_AA_AA_AA_AA_AA},  // consecutive, dlc 0
    '{CHK_NONE,    4'd1,  64'h22_AA_AA_AA_AA_AA_AA_AA},  // consecutive, dlc 1
    '{CHK_MODEL,   4'd8,  64'h23_00_FF_55_AA_01_02_03},
    '{CHK_MODEL,   4'd15, 64'h24_10_20_30_40_50_60_70},  // dlc above 8, completes
    '{CHK_NONE,    4'd8,  64'h25_01_02_03_04_05_06_07},  // after completion
    '{CHK_MODEL,   4'd8,  64'h10_03_C1_C2_C3_C4_C5_C6},  // length shorter than frame
    '{CHK_FC_ONLY, 4'd2,  64'h10_0A_11_11_11_11_11_11},  // short first frame
    '{CHK_FC_ONLY, 4'd0,  64'h1F_FF_22_22_22_22_22_22},  // dlc 0 first frame
    '{CHK_MODEL,   4'd9,  64'h1F_FF_80_81_82_83_84_85},  // maximum length, dlc 9
    '{CHK_MODEL,   4'd4,  64'h2F_EE_DD_CC_BB_AA_99_88},
    '{CHK_MODEL,   4'd8,  64'h10_64_01_02_03_04_05_06},  // abandon running message
    '{CHK_MODEL,   4'd8,  64'h10_08_F0_F1_F2_F3_F4_F5},  // and again
    '{CHK_MODEL,   4'd8,  64'h21_E0_E1_E2_E3_E4_E5_E6},  // overshoot dropped
    '{CHK_MODEL,   4'd5,  64'h10_05_A0_A1_A2_A3_A4_A5},
    '{CHK_MODEL,   4'd3,  64'h21_B0_B1_B2_B3_B4_B5_B6}
  };

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [3:0]  in_length_code;
  logic [7:0]  in_byte0, in_byte1, in_byte2, in_byte3;
  logic [7:0]  in_byte4, in_byte5, in_byte6, in_byte7;
  logic        out_empty;
  logic        out_pop;
  logic        out_kind;
  logic [7:0]  out_payload_byte;
  logic [11:0] out_byte_index;
  logic        out_message_done;
  logic        out_last;

  // predictor state
  int          msg_len;
  int          msg_count;
  bit          msg_active;
  rx_result_t  frame_out[$];
  rx_result_t  pending_rx[$];

  bit          no_idle;
  int          hold_cycles;
  int          n_err;
  int          n_frames;
  int          n_results;
  int          n_fc;
  int          n_done;

  iso_tp_receive_reassembler i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_length_code   (in_length_code),
    .in_byte0         (in_byte0),
    .in_byte1         (in_byte1),
    .in_byte2         (in_byte2),
    .in_byte3         (in_byte3),
    .in_byte4         (in_byte4),
    .in_byte5         (in_byte5),
    .in_byte6         (in_byte6),
    .in_byte7         (in_byte7),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_message_done (out_message_done),
    .out_last         (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Fill frame_out with what one frame produces and advance the message state.
  function automatic void reassemble_frame(input logic [3:0] dlc_in,
                                           input logic [0:7][7:0] b);
    int         dlc;
    int         n_cand;
    int         first;
    rx_result_t r;
    frame_out.delete();
    dlc = (dlc_in > 4'd8) ? 8 : int'(dlc_in);
    n_cand = 0;
    first = 0;
    if (b[0][7:4] == FT_FIRST) begin
      msg_len = {b[0][3:0], b[1]};
      if (msg_len > MAX_MESSAGE_BYTES) msg_len = MAX_MESSAGE_BYTES;
      msg_count = 0;
      msg_active = (msg_len != 0);
      n_cand = (dlc > 2) ? dlc - 2 : 0;
      first = 2;
    end else if (b[0][7:4] == FT_CONSECUTIVE && msg_active) begin
      n_cand = (dlc > 1) ? dlc - 1 : 0;
      first = 1;
    end
    for (int i = 0; i < n_cand; i++) begin
      // drop bytes past the announced length
      if (msg_active && msg_count < msg_len) begin
        r.kind = OUT_KIND_BYTE;
        r.data = b[first + i];
        r.idx  = msg_count[11:0];
        r.done = (msg_count + 1 == msg_len);
        r.last = 1'b0;
        frame_out.push_back(r);
        msg_count++;
        if (r.done) msg_active = 0;
      end
    end
    if (b[0][7:4] == FT_FIRST) begin
      frame_out.push_back(rx_result_t'{OUT_KIND_FC, 8'h00, 12'h000, 1'b0, 1'b0});
    end
    if (frame_out.size() > 0) frame_out[frame_out.size() - 1].last = 1'b1;
  endfunction

  // Offer one frame after a random gap; hold it until accepted, then queue its results.
  task automatic offer_frame(input logic [3:0] dlc, input logic [0:7][7:0] b, input chk_t chk);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push        <= 1'b1;
    in_length_code <= dlc;
    in_byte0 <= b[0];
    in_byte1 <= b[1];
    in_byte2 <= b[2];
    in_byte3 <= b[3];
    in_byte4 <= b[4];
    in_byte5 <= b[5];
    in_byte6 <= b[6];
    in_byte7 <= b[7];
    do @(posedge clk); while (in_full);
    n_frames++;
    reassemble_frame(dlc, b);
    case (chk)
      CHK_MODEL:   foreach (frame_out[i]) pending_rx.push_back(frame_out[i]);
      CHK_FC_ONLY: pending_rx.push_back(FC_ALONE);
      default: ;
    endcase
  endtask

  // receiver: random pop gaps plus one long hold-off on request
  initial begin
    int pop_gap;
    out_pop = 1'b0;
    pop_gap = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_pop <= 1'b0;
        hold_cycles--;
      end else if (pop_gap > 0) begin
        out_pop <= 1'b0;
        pop_gap--;
      end else begin
        out_pop <= 1'b1;
        pop_gap = no_idle ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    rx_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      n_results++;
      if (out_kind == OUT_KIND_FC) n_fc++;
      if (out_message_done) n_done++;
      if (pending_rx.size() == 0) begin
        $error("unexpected result: kind %0d byte %0h index %0d", out_kind,
               out_payload_byte, out_byte_index);
        n_err++;
      end else begin
        want = pending_rx.pop_front();
        if (out_kind !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
          n_err++;
        end
        if (out_payload_byte !== want.data) begin
          $error("out_payload_byte: expected %0h, got %0h", want.data, out_payload_byte);
          n_err++;
        end
        if (out_byte_index !== want.idx) begin
          $error("out_byte_index: expected %0d, got %0d", want.idx, out_byte_index);
          n_err++;
        end
        if (out_message_done !== want.done) begin
          $error("out_message_done: expected %0d, got %0d", want.done, out_message_done);
          n_err++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0d, got %0d", want.last, out_last);
          n_err++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int              rand_items;
    int              len;
    int              r;
    logic [3:0]      dlc;
    logic [0:7][7:0] b;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_length_code = '0;
    {in_byte0, in_byte1, in_byte2, in_byte3} = '0;
    {in_byte4, in_byte5, in_byte6, in_byte7} = '0;
    msg_len = 0;
    msg_count = 0;
    msg_active = 0;
    no_idle = 0;
    hold_cycles = 0;
    n_err = 0;
    n_frames = 0;
    n_results = 0;
    n_fc = 0;
    n_done = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) offer_frame(DIR_TBL[i].dlc, DIR_TBL[i].b, DIR_TBL[i].chk);

    // stall the receiver while the sender keeps pushing
    hold_cycles = 400;
    rand_items = 0;
    while (rand_items < 100) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 8) begin
        r = $urandom_range(0, 9);
        if (r == 0) len = 0;
        else if (r < 7) len = $urandom_range(1, 30);
        else len = $urandom_range(31, 150);
        dlc = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
        b[0] = {FT_FIRST, 4'(len >> 8)};
        b[1] = 8'(len);
        for (int i = 2; i < 8; i++) b[i] = 8'($urandom_range(0, 255));
        offer_frame(dlc, b, CHK_MODEL);
        rand_items++;
        while (msg_active && rand_items < 100) begin
          r = $urandom_range(0, 19);
          if (r == 0) break;  // abandon: next sequence starts over
          for (int i = 0; i < 8; i++) b[i] = 8'($urandom_range(0, 255));
          dlc = 4'($urandom_range(0, 15));
          if (r > 1) begin
            b[0][7:4] = FT_CONSECUTIVE;
            if (r < 16) dlc = 4'd8;
          end
          offer_frame(dlc, b, CHK_MODEL);
          rand_items++;
        end
      end else begin
        for (int i = 0; i < 8; i++) b[i] = 8'($urandom_range(0, 255));
        offer_frame(4'($urandom_range(0, 15)), b, CHK_MODEL);
        rand_items++;
      end
    end
    no_idle = 0;

    @(negedge clk);
    in_push <= 1'b0;
    while (pending_rx.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Run covered %0d frames and %0d results: %0d flow-control requests, %0d messages done.",
             n_frames, n_results, n_fc, n_done);
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/isotp_pkg.sv
rtl/core/isotp_front.sv
rtl/core/isotp_cmd_fifo.sv
rtl/core/isotp_back.sv
rtl/core/iso_tp_receive_reassembler.sv
verif/tb_top.sv
